// ----- rtl/core/slal_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment list allocator package
// Shared constants, state codes, cell commands and status codes.
// ----------------------------------------------------------------------------
package slal_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int SIZE_BITS_DEF    = 16;
  localparam int OWNER_W          = 8;
  localparam int STATUS_W         = 3;
  localparam int MEM_SIZE_RST     = 4096;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_WRITE,
    OP_SPLIT,
    OP_CLOSE1,
    OP_CLOSE2
  } cell_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_INDEX  = 3'd1,
    STAT_TOO_SMALL  = 3'd2,
    STAT_NOT_FREE   = 3'd3,
    STAT_ALREADY    = 3'd4,
    STAT_TABLE_FULL = 3'd5
  } status_t;

endpackage

// ----- rtl/core/segment_list_allocator.sv -----
// Each word passes through a lookup state, which gathers the target entry and its
// neighbors from the cell row, then an update state, in which the cells beyond the
// target shift by up to two places at once. The update, which registers the result
// word and may take the next word, waits while an earlier result is still unread.
// Reset is synchronous; the table returns at once to one free segment of 4096.
// ----------------------------------------------------------------------------
// Segment list allocator
// Ordered table of contiguous segments kept in a row of shifting cells, with
// split on allocate and coalescing with free neighbors on release.
// ----------------------------------------------------------------------------
module segment_list_allocator import slal_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [SIZE_BITS-1:0]                cfg_memory_size,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]     in_segment_index,
  input  logic [SIZE_BITS-1:0]                in_request_size,
  input  logic [OWNER_W-1:0]                  in_process_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [STATUS_W-1:0]                 out_status,
  output logic [$clog2(MAX_SEGMENTS)-1:0]     out_result_index,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]   out_segment_count
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = SIZE_BITS + 1 + OWNER_W;

  typedef struct packed {
    logic [SIZE_BITS-1:0] len;
    logic                 free;
    logic [OWNER_W-1:0]   owner;
  } seg_entry_t;

  state_t               st_r;
  state_t               st_nxt;
  logic                 func_r;
  logic [IW-1:0]        idx_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [OWNER_W-1:0]   pid_r;
  logic [CW-1:0]        total_r;
  logic [CW-1:0]        total_nxt;
  seg_entry_t           cur_r;
  seg_entry_t           prev_r;
  seg_entry_t           next_r;
  seg_entry_t           cur_nxt;
  seg_entry_t           prev_nxt;
  seg_entry_t           next_nxt;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [IW-1:0]        out_result_index_r;
  logic [CW-1:0]        out_segment_count_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 apply_done;
  status_t              status;
  logic [IW-1:0]        res_idx;
  cell_op_t             dec_op;
  logic [IW-1:0]        dec_pos;
  seg_entry_t           dec_wdata;
  seg_entry_t           dec_wdata2;
  logic [CW-1:0]        dec_total;
  logic                 nfree;
  logic                 pfree;
  logic [SIZE_BITS-1:0] sum;

  cell_op_t             cell_op;
  logic [IW-1:0]        cell_pos;
  logic [EW-1:0]        cell_wdata;
  logic [EW-1:0]        cell_wdata2;

  logic [EW-1:0]        cell_q   [MAX_SEGMENTS];
  logic [EW-1:0]        sel_cur  [MAX_SEGMENTS];
  logic [EW-1:0]        sel_prev [MAX_SEGMENTS];
  logic [EW-1:0]        sel_next [MAX_SEGMENTS];

  assign out_free   = !out_valid_r || out_ready;
  assign apply_done = (st_r == ST_APPLY) && out_free;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          st_nxt = in_valid ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cell_op     = OP_HOLD;
    cell_pos    = dec_pos;
    cell_wdata  = dec_wdata;
    cell_wdata2 = dec_wdata2;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOK: begin
        in_ready = 1'b0;
      end
      ST_APPLY: begin
        in_ready = out_free;
        if (out_free) begin
          cell_op = dec_op;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    if (cfg_wr_en) begin
      cell_op    = OP_INIT;
      cell_wdata = {cfg_memory_size, 1'b1, OWNER_W'(0)};
    end
  end

  always_comb begin
    nfree      = next_r.free;
    pfree      = (idx_r != '0) && prev_r.free;
    sum        = cur_r.len + (nfree ? next_r.len : '0) + (pfree ? prev_r.len : '0);
    status     = STAT_OK;
    res_idx    = '0;
    dec_op     = OP_HOLD;
    dec_pos    = idx_r;
    dec_wdata  = '{len: req_r, free: 1'b0, owner: pid_r};
    dec_wdata2 = '{len: cur_r.len - req_r, free: 1'b1, owner: '0};
    dec_total  = total_r;
    if (CW'(idx_r) >= total_r) begin
      status = STAT_BAD_INDEX;
    end else if (!func_r) begin
      if (cur_r.len < req_r) begin
        status = STAT_TOO_SMALL;
      end else if (!cur_r.free) begin
        status = STAT_NOT_FREE;
      end else if (cur_r.len > req_r && total_r >= CW'(MAX_SEGMENTS)) begin
        status = STAT_TABLE_FULL;
      end else if (cur_r.len > req_r) begin
        res_idx   = idx_r;
        dec_op    = OP_SPLIT;
        dec_total = total_r + CW'(1);
      end else begin
        res_idx = idx_r;
        dec_op  = OP_WRITE;
      end
    end else begin
      if (cur_r.free) begin
        status = STAT_ALREADY;
      end else begin
        dec_wdata = '{len: sum, free: 1'b1, owner: '0};
        if (pfree) begin
          res_idx = idx_r - IW'(1);
          dec_pos = idx_r - IW'(1);
        end else begin
          res_idx = idx_r;
        end
        if (pfree && nfree) begin
          dec_op    = OP_CLOSE2;
          dec_total = total_r - CW'(2);
        end else if (pfree || nfree) begin
          dec_op    = OP_CLOSE1;
          dec_total = total_r - CW'(1);
        end else begin
          dec_op = OP_WRITE;
        end
      end
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (cfg_wr_en) begin
      total_nxt = CW'(1);
    end else if (apply_done) begin
      total_nxt = dec_total;
    end
  end

  always_comb begin
    cur_nxt  = '0;
    prev_nxt = '0;
    next_nxt = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      cur_nxt  = cur_nxt | sel_cur[i];
      prev_nxt = prev_nxt | sel_prev[i];
      next_nxt = next_nxt | sel_next[i];
    end
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    logic [EW-1:0] left_q;
    logic [EW-1:0] right1_q;
    logic [EW-1:0] right2_q;

    if (g == 0) begin : g_left_edge
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[g-1];
    end
    if (g + 1 >= MAX_SEGMENTS) begin : g_right1_edge
      assign right1_q = '0;
    end else begin : g_right1
      assign right1_q = cell_q[g+1];
    end
    if (g + 2 >= MAX_SEGMENTS) begin : g_right2_edge
      assign right2_q = '0;
    end else begin : g_right2
      assign right2_q = cell_q[g+2];
    end

    slal_cell #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .SIZE_BITS    (SIZE_BITS),
      .POS          (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op),
      .wpos     (cell_pos),
      .wdata    (cell_wdata),
      .wdata2   (cell_wdata2),
      .left_q   (left_q),
      .right1_q (right1_q),
      .right2_q (right2_q),
      .look_pos (idx_r),
      .q        (cell_q[g]),
      .sel_cur  (sel_cur[g]),
      .sel_prev (sel_prev[g]),
      .sel_next (sel_next[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      total_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      total_r <= total_nxt;
      if (apply_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      idx_r  <= in_segment_index;
      req_r  <= in_request_size;
      pid_r  <= in_process_id;
    end
    if (st_r == ST_LOOK) begin
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
      next_r <= next_nxt;
    end
    if (apply_done) begin
      out_status_r        <= status;
      out_result_index_r  <= res_idx;
      out_segment_count_r <= dec_total;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_index  = out_result_index_r;
  assign out_segment_count = out_segment_count_r;

`ifndef SYNTHESIS
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) && (total_r <= CW'(MAX_SEGMENTS)))
    else $error("Segment count left its legal range.");

  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_done && !cfg_wr_en && cell_op == OP_SPLIT) |=> (total_r == $past(total_r) + CW'(1)))
    else $error("A split did not add one segment.");

  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_done && !cfg_wr_en && status != STAT_OK) |-> (cell_op == OP_HOLD))
    else $error("A failed request changed the table.");

  a_look_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOOK) |=> (st_r == ST_APPLY))
    else $error("Lookup was not followed by the update cycle.");
`endif

endmodule

// ----- rtl/core/slal_cell.sv -----
// ----------------------------------------------------------------------------
// Segment table cell
// Holds one table entry, shifts with its neighbors on insert and remove,
// and offers its entry when it sits at or beside the looked-up position.
// ----------------------------------------------------------------------------
module slal_cell import slal_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = SIZE_BITS_DEF,
  parameter int POS          = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cell_op_t                              op,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]       wpos,
  input  logic [SIZE_BITS+OWNER_W:0]            wdata,
  input  logic [SIZE_BITS+OWNER_W:0]            wdata2,
  input  logic [SIZE_BITS+OWNER_W:0]            left_q,
  input  logic [SIZE_BITS+OWNER_W:0]            right1_q,
  input  logic [SIZE_BITS+OWNER_W:0]            right2_q,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]       look_pos,
  output logic [SIZE_BITS+OWNER_W:0]            q,
  output logic [SIZE_BITS+OWNER_W:0]            sel_cur,
  output logic [SIZE_BITS+OWNER_W:0]            sel_prev,
  output logic [SIZE_BITS+OWNER_W:0]            sel_next
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int EW = SIZE_BITS + 1 + OWNER_W;
  localparam logic [IW:0] POS_X = (IW+1)'(POS);
  localparam logic [EW-1:0] RST_Q =
    (POS == 0) ? {SIZE_BITS'(MEM_SIZE_RST), 1'b1, OWNER_W'(0)} : '0;

  logic [EW-1:0] q_r;
  logic [EW-1:0] q_nxt;
  logic [IW:0]   wpos_x;
  logic [IW:0]   look_x;
  logic          at;
  logic          at1;
  logic          gt;
  logic          gt1;

  assign wpos_x = {1'b0, wpos};
  assign look_x = {1'b0, look_pos};
  assign at     = (POS_X == wpos_x);
  assign at1    = (POS_X == wpos_x + (IW+1)'(1));
  assign gt     = (POS_X > wpos_x);
  assign gt1    = (POS_X > wpos_x + (IW+1)'(1));

  always_comb begin
    q_nxt = q_r;
    case (op)
      OP_INIT: begin
        q_nxt = (POS == 0) ? wdata : '0;
      end
      OP_WRITE: begin
        if (at) begin
          q_nxt = wdata;
        end
      end
      OP_SPLIT: begin
        if (at) begin
          q_nxt = wdata;
        end else if (at1) begin
          q_nxt = wdata2;
        end else if (gt1) begin
          q_nxt = left_q;
        end
      end
      OP_CLOSE1: begin
        if (at) begin
          q_nxt = wdata;
        end else if (gt) begin
          q_nxt = right1_q;
        end
      end
      OP_CLOSE2: begin
        if (at) begin
          q_nxt = wdata;
        end else if (gt) begin
          q_nxt = right2_q;
        end
      end
      default: begin
        q_nxt = q_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= RST_Q;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q        = q_r;
  assign sel_cur  = (POS_X == look_x) ? q_r : '0;
  assign sel_prev = (POS_X + (IW+1)'(1) == look_x) ? q_r : '0;
  assign sel_next = (POS_X == look_x + (IW+1)'(1)) ? q_r : '0;

endmodule
